// ----- hdl/tcbf_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tcbf_pkg
// Shared widths, codes and controller/datapath interface types for the
// tandem counting Bloom filter core.
// ---------------------------------------------------------------------------
package tcbf_pkg;

    // Field widths of one probe and one result
    localparam int OP_W    = 2;
    localparam int POS_W   = 10;
    localparam int VAR_W   = 6;
    localparam int TAG_W   = 5;
    localparam int LEVEL_W = 6;
    localparam int CNT8_W  = 8;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_LEVEL_SIZE = 1'b0;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 6'd4;

    // Parameter defaults
    localparam int DEF_COUNTERS   = 1024;
    localparam int DEF_MAX_PROBES = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // One buffered remove probe
    typedef struct packed {
        logic [VAR_W-1:0] var_value;
        logic [POS_W-1:0] position;
    } t_probe;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_en;     // zero one store row, advance clear pointer
        logic accept;     // capture the probe, read its counter pair
        logic exec;       // evaluate the probe, write back an insert, update match/buffer
        logic walk_rd;    // fetch buffered probe, read its counter pair
        logic walk_ex;    // apply remove to the fetched pair
        logic load_out;   // move a result into the output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_done;   // clear pointer on the last row
        logic is_last;    // current probe closes its operation
        logic apply_rm;   // remove passed: walk the buffer
        logic walk_done;  // current walk entry is the last buffered one
        logic out_free;   // output register can take a result this cycle
    } t_dp_stat;

endpackage : tcbf_pkg
`default_nettype wire

// ----- hdl/tcbf_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tcbf_ctrl
// Sequencing state machine: store clear after reset, probe read and
// write-back, remove walk over buffered probes, and result hand-off.
// ---------------------------------------------------------------------------
module tcbf_ctrl
    import tcbf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_WRD   = 6'b001000,
        ST_WEX   = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (!i_stat.is_last) begin
                    n_state = ST_IDLE;
                end else if (i_stat.apply_rm) begin
                    n_state = ST_WRD;
                end else if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_WRD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = ST_WEX;
            end
            ST_WEX: begin
                o_cmd.walk_ex = 1'b1;
                if (!i_stat.walk_done) begin
                    n_state = ST_WRD;
                end else if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule : tcbf_ctrl
`default_nettype wire

// ----- hdl/tcbf_datapath.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tcbf_datapath
// Counter-pair store, probe evaluation (insert update, pass check, remove
// update), remove probe buffer, match tracking and the output register.
// ---------------------------------------------------------------------------
module tcbf_datapath
    import tcbf_pkg::*;
#(
    parameter int COUNTERS   = DEF_COUNTERS,
    parameter int MAX_PROBES = DEF_MAX_PROBES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [POS_W-1:0]   i_position,
    input  wire logic [VAR_W-1:0]   i_var_value,
    input  wire logic [TAG_W-1:0]   i_tag_value,
    input  wire logic               i_last_probe,
    input  wire logic [LEVEL_W-1:0] i_level_size,
    input  wire logic               i_m_tready,
    output logic                    o_m_tvalid,
    output logic [OP_W-1:0]         o_op_done,
    output logic                    o_verdict
);

    localparam int ROWS  = COUNTERS / 2;
    localparam int ROW_W = $clog2(ROWS);
    localparam int IDX_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam int CNT_W = $clog2(MAX_PROBES + 1);
    localparam int ARW   = 11;  // signed width for counter arithmetic

    // Store and buffer
    logic [2*CNT8_W-1:0] r_mem [ROWS];
    t_probe              r_buf [MAX_PROBES];

    // Current probe
    logic [OP_W-1:0]  r_op;
    logic [POS_W-1:0] r_pos;
    logic [VAR_W-1:0] r_var;
    logic [TAG_W-1:0] r_tag;
    logic             r_last;

    logic [2*CNT8_W-1:0] r_rd_word;
    logic [ROW_W-1:0]    r_clr_row;
    logic [CNT_W-1:0]    r_count;
    logic                r_match;
    logic [IDX_W-1:0]    r_widx;
    t_probe              r_wprobe;
    logic [OP_W-1:0]     r_res_op;
    logic                r_res_verdict;
    logic                r_out_valid;
    logic [OP_W-1:0]     r_out_op;
    logic                r_out_verdict;

    // Row of a counter index (counter 2n and 2n+1 share row n)
    logic [31:0]      in_wide, cur_wide, buf_wide, walk_wide;
    logic [ROW_W-1:0] in_row, cur_row, buf_row, walk_row;
    t_probe           buf_entry;

    assign buf_entry = r_buf[r_widx];
    assign in_wide   = 32'(i_position);
    assign cur_wide  = 32'(r_pos);
    assign buf_wide  = 32'(buf_entry.position);
    assign walk_wide = 32'(r_wprobe.position);
    assign in_row    = in_wide[ROW_W:1];
    assign cur_row   = cur_wide[ROW_W:1];
    assign buf_row   = buf_wide[ROW_W:1];
    assign walk_row  = walk_wide[ROW_W:1];

    // Effective level: values other than 2, 4, 8, 16 or 32 act as 4
    logic signed [ARW-1:0] lv, lv2, lv4m2;
    always_comb begin
        case (i_level_size) inside
            6'd2, 6'd4, 6'd8, 6'd16, 6'd32: lv = ARW'(i_level_size);
            default:                        lv = ARW'(LEVEL_RESET);
        endcase
        lv2   = lv + lv;
        lv4m2 = lv2 + lv2 - 11'sd2;
    end

    // Select probed counter and partner from the read word
    logic                  odd;
    logic [CNT8_W-1:0]     b1, b2;
    logic signed [ARW-1:0] c1, c2, v, t;
    always_comb begin
        odd = i_cmd.walk_ex ? r_wprobe.position[0] : r_pos[0];
        b1  = odd ? r_rd_word[15:8] : r_rd_word[7:0];
        b2  = odd ? r_rd_word[7:0]  : r_rd_word[15:8];
        c1  = ARW'(b1);
        c2  = ARW'(b2);
        v   = i_cmd.walk_ex ? ARW'(r_wprobe.var_value) : ARW'(r_var);
        t   = ARW'(r_tag);
    end

    // Pass check of a lookup or remove probe
    logic pass;
    always_comb begin
        pass = 1'b1;
        if (c1 < v || (c1 - v >= 11'sd1 && c1 - v < lv)) begin
            pass = 1'b0;
        end else if (c1 < lv2) begin
            if (c1 != v) begin
                pass = 1'b0;
            end else if (c2 >= 11'sd1 && c2 < lv && c2 != t) begin
                pass = 1'b0;
            end
        end else if (c2 >= 11'sd1 && c2 < lv) begin
            if (c2 == 11'sd1 && c1 == lv4m2) begin
                if (lv2 - 11'sd1 != v) begin
                    pass = 1'b0;
                end
            end else if (c2 + lv - 11'sd1 != v && c1 - c2 - lv + 11'sd1 != v) begin
                pass = 1'b0;
            end
        end
    end

    // Insert update of the pair
    logic [CNT8_W-1:0]     ins1, ins2;
    logic signed [ARW-1:0] va, cb, cs;
    always_comb begin
        va   = v - lv + 11'sd1;
        cb   = c1 - lv + 11'sd1;
        cs   = c1 + v;
        ins1 = b1;
        ins2 = b2;
        if (c1 < lv) begin
            ins1 = v[CNT8_W-1:0];
            if (c2 == 11'sd0) begin
                ins2 = t[CNT8_W-1:0];
            end
        end else begin
            if (c1 < lv2) begin
                if (c2 < lv) begin
                    if (va < lv) begin
                        ins2 = va[CNT8_W-1:0];
                    end else if (cb < lv) begin
                        ins2 = cb[CNT8_W-1:0];
                    end else begin
                        ins2 = 8'd1;
                    end
                end
            end else if (c2 >= 11'sd1 && c2 < lv) begin
                ins2 = '0;
            end
            if (c1 <= 11'sd255 - v) begin
                ins1 = cs[CNT8_W-1:0];
            end
        end
    end

    // Remove update of the pair
    logic [CNT8_W-1:0]     rm1, rm2;
    logic signed [ARW-1:0] cd;
    always_comb begin
        cd  = c1 - v;
        rm1 = b1;
        if (c1 >= lv && c1 < lv2) begin
            rm1 = '0;
        end else if (v <= c1) begin
            rm1 = cd[CNT8_W-1:0];
        end
        rm2 = (c2 >= 11'sd1 && c2 < lv) ? '0 : b2;
    end

    // Match, buffer and verdict of the current probe
    logic             is_insert, is_remove, has_room;
    logic             n_match, verdict_c, apply_c;
    logic [CNT_W-1:0] n_count;
    always_comb begin
        is_insert = (r_op == OP_INSERT);
        is_remove = (r_op == OP_REMOVE);
        has_room  = (r_count < CNT_W'(MAX_PROBES));
        n_match   = r_match;
        n_count   = r_count;
        if (!is_insert) begin
            n_match = r_match & pass;
            if (is_remove) begin
                if (has_room) begin
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_match = 1'b0;
                end
            end
        end
        verdict_c = is_insert ? 1'b1 : n_match;
        apply_c   = r_last && is_remove && verdict_c;
    end

    // Store write and read port selection
    logic                wr_en;
    logic [ROW_W-1:0]    wr_row;
    logic [2*CNT8_W-1:0] wr_word;
    logic                rd_en;
    logic [ROW_W-1:0]    rd_row;
    always_comb begin
        wr_en   = 1'b0;
        wr_row  = cur_row;
        wr_word = odd ? {ins1, ins2} : {ins2, ins1};
        if (i_cmd.clr_en) begin
            wr_en   = 1'b1;
            wr_row  = r_clr_row;
            wr_word = '0;
        end else if (i_cmd.exec && is_insert) begin
            wr_en = 1'b1;
        end else if (i_cmd.walk_ex) begin
            wr_en   = 1'b1;
            wr_row  = walk_row;
            wr_word = odd ? {rm1, rm2} : {rm2, rm1};
        end
        rd_en  = i_cmd.accept | i_cmd.walk_rd;
        rd_row = i_cmd.accept ? in_row : buf_row;
    end

    // Counter-pair store
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_word <= r_mem[rd_row];
        end
        if (wr_en) begin
            r_mem[wr_row] <= wr_word;
        end
    end

    // Capture probe fields on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_pos  <= i_position;
            r_var  <= i_var_value;
            r_tag  <= i_tag_value;
            r_last <= i_last_probe;
        end
    end

    // Buffer remove probes; fetch them during the walk; hold the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && is_remove && has_room) begin
            r_buf[r_count[IDX_W-1:0]] <= '{var_value: r_var, position: r_pos};
        end
        if (i_cmd.walk_rd) begin
            r_wprobe <= buf_entry;
        end
        if (i_cmd.exec && r_last) begin
            r_res_op      <= r_op;
            r_res_verdict <= verdict_c;
        end
    end

    // Control state: clear pointer, probe count, match flag, walk index
    logic walk_done;
    assign walk_done = (CNT_W'(CNT_W'(r_widx) + CNT_W'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
            r_count   <= '0;
            r_match   <= 1'b1;
            r_widx    <= '0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
            end
            if (i_cmd.exec) begin
                r_widx <= '0;
                if (r_last) begin
                    r_match <= 1'b1;
                    r_count <= apply_c ? n_count : '0;
                end else begin
                    r_match <= n_match;
                    r_count <= n_count;
                end
            end
            if (i_cmd.walk_ex) begin
                r_widx <= r_widx + IDX_W'(1);
                if (walk_done) begin
                    r_count <= '0;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_op      <= i_cmd.exec ? r_op : r_res_op;
            r_out_verdict <= i_cmd.exec ? verdict_c : r_res_verdict;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_op_done  = r_out_op;
    assign o_verdict  = r_out_verdict;

    // Status to controller
    always_comb begin
        o_stat.clr_done  = (r_clr_row == ROW_W'(ROWS - 1));
        o_stat.is_last   = r_last;
        o_stat.apply_rm  = apply_c;
        o_stat.walk_done = walk_done;
        o_stat.out_free  = !r_out_valid || i_m_tready;
    end

endmodule : tcbf_datapath
`default_nettype wire

// ----- hdl/tandem_counting_bloom_filter_core.sv -----
`default_nettype none
// Sequence: a probe takes accept + store read, then evaluate + write back; a final insert
//   or lookup probe loads its result into the output register if it is free, else waits.
// A passing final remove then walks its buffered probes, each by fetch + read, then
//   update + write back. A probe is accepted only once the previous one is through.
// Reset: synchronous; the store is zeroed one row per cycle, with no probe accepted
//   meanwhile; level_size returns to 4. A full output register stalls input.
// ---------------------------------------------------------------------------
// tandem_counting_bloom_filter_core
// Top level: stream ports, APB configuration register, controller and
// datapath.
// ---------------------------------------------------------------------------
module tandem_counting_bloom_filter_core
    import tcbf_pkg::*;
#(
    parameter int COUNTERS   = DEF_COUNTERS,
    parameter int MAX_PROBES = DEF_MAX_PROBES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // probe stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // tdata: op[1:0], position[11:2], var_value[17:12], tag_value[22:18], zero[23]
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                  i_s_tlast,   // last_probe
    // result stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // tdata: op_done[1:0], verdict[2], zero[7:3]
    output logic [M_TDATA_W-1:0]       o_m_tdata,
    // configuration
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0]      o_prdata,
    output logic                       o_pready
);

    logic [LEVEL_W-1:0] r_level_size;
    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [OP_W-1:0]    op_done;
    logic               verdict;
    logic               reg_hit;

    // Register decode: one register at byte address 0
    assign reg_hit  = (i_paddr[2] == REG_LEVEL_SIZE);
    assign o_pready = 1'b1;

    // Write level_size on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_size <= LEVEL_RESET;
        end else if (i_psel && i_penable && i_pwrite && reg_hit) begin
            r_level_size <= i_pwdata[LEVEL_W-1:0];
        end
    end

    assign o_prdata = reg_hit ? APB_DATA_W'(r_level_size) : '0;

    tcbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tcbf_datapath #(
        .COUNTERS   (COUNTERS),
        .MAX_PROBES (MAX_PROBES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_op         (i_s_tdata[1:0]),
        .i_position   (i_s_tdata[11:2]),
        .i_var_value  (i_s_tdata[17:12]),
        .i_tag_value  (i_s_tdata[22:18]),
        .i_last_probe (i_s_tlast),
        .i_level_size (r_level_size),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_op_done    (op_done),
        .o_verdict    (verdict)
    );

    // Pack result transaction
    assign o_m_tdata = {5'b0, verdict, op_done};

endmodule : tandem_counting_bloom_filter_core
`default_nettype wire
